>>> src/llst_pkg.sv
// Shared types and codes of the least-loaded session table.
package llst_pkg;

  localparam int unsigned DefMaxSessions = 16;
  localparam int unsigned DefMaxPairs    = 256;

  typedef enum logic [2:0] {
    OP_ADD_SESS = 3'd0,
    OP_ADD_KEY  = 3'd1,
    OP_DEL_SESS = 3'd2,
    OP_DEL_KEY  = 3'd3,
    OP_FIND     = 3'd4
  } op_e;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic s_clr;
    logic s_step;
    logic p_clr;
    logic p_step;
    logic commit;
  } llst_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic s_last;
    logic p_last;
    logic p_needed;
    logic out_stall;
  } llst_stat_t;

endpackage

>>> src/llst_if.sv
// Channel interfaces: operation words in, result words out.
interface llst_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [31:0] session_id;
  logic [31:0] client_key;
  modport source (output valid, output op, output session_id, output client_key, input ready);
  modport sink   (input valid, input op, input session_id, input client_key, output ready);
endinterface

interface llst_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        found;
  logic [31:0] selected_session;
  modport source (output valid, output status, output found, output selected_session,
                  input ready);
  modport sink   (input valid, input status, input found, input selected_session,
                  output ready);
endinterface

>>> src/llst_ctrl.sv
// Sequencer of the session scan, the pair scan and the commit of one operation.
module llst_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  llst_pkg::llst_stat_t  stat_i,
  output llst_pkg::llst_cmd_t   cmd_o
);

  typedef enum logic [2:0] {
    IDLE,
    S_SCAN,
    P_SEL,
    P_SCAN,
    P_DRAIN,
    COMMIT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      IDLE: begin
        if (in_valid_i) begin
          cmd_o.load  = 1'b1;
          cmd_o.s_clr = 1'b1;
          state_d     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.s_step = 1'b1;
        if (stat_i.s_last) state_d = P_SEL;
      end
      P_SEL: begin
        if (stat_i.p_needed) begin
          cmd_o.p_clr = 1'b1;
          state_d     = P_SCAN;
        end else begin
          state_d = COMMIT;
        end
      end
      P_SCAN: begin
        cmd_o.p_step = 1'b1;
        if (stat_i.p_last) state_d = P_DRAIN;
      end
      P_DRAIN: state_d = COMMIT;
      COMMIT: begin
        // hold until the result register is free
        if (!stat_i.out_stall) begin
          cmd_o.commit = 1'b1;
          state_d      = IDLE;
        end
      end
      default: state_d = IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == IDLE);

endmodule

>>> src/llst_dp.sv
// Session table, pair store, scan accumulators and result register.
module llst_dp #(
  parameter int unsigned MAX_SESSIONS = llst_pkg::DefMaxSessions,
  parameter int unsigned MAX_PAIRS    = llst_pkg::DefMaxPairs
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  llst_pkg::llst_cmd_t   cmd_i,
  output llst_pkg::llst_stat_t  stat_o,
  input  logic [2:0]            op_i,
  input  logic [31:0]           session_id_i,
  input  logic [31:0]           client_key_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            status_o,
  output logic                  found_o,
  output logic [31:0]           selected_session_o
);

  localparam int unsigned SW = $clog2(MAX_SESSIONS);
  localparam int unsigned PW = $clog2(MAX_PAIRS);
  localparam int unsigned CW = $clog2(MAX_PAIRS + 1);
  localparam logic [SW-1:0] SLast = SW'(MAX_SESSIONS - 1);
  localparam logic [PW-1:0] PLast = PW'(MAX_PAIRS - 1);

  // operation word
  logic [2:0]  op_q;
  logic [31:0] id_q, key_q;

  // session table
  logic [31:0]       sess_ident_q [MAX_SESSIONS];
  logic [CW-1:0]     sess_cnt_q   [MAX_SESSIONS];
  logic [MAX_SESSIONS-1:0] sess_vld_q;

  // session scan
  logic [SW-1:0] s_idx_q;
  logic          hit_q, sfree_q, best_q;
  logic [SW-1:0] hit_slot_q, sfree_slot_q;
  logic [CW-1:0] best_cnt_q;
  logic [31:0]   best_id_q;

  // pair store
  logic [31:0]   pair_key_mem   [MAX_PAIRS];
  logic [SW-1:0] pair_owner_mem [MAX_PAIRS];
  logic [MAX_PAIRS-1:0] pv_q;

  // pair scan
  logic [PW-1:0] p_idx_q, cmp_idx_q, pfree_idx_q;
  logic          cmp_v_q, match_q, pfree_q;
  logic [31:0]   rk_q;
  logic [SW-1:0] ro_q;

  // result register
  logic        out_valid_q;
  logic [1:0]  status_q;
  logic        found_q;
  logic [31:0] sel_q;

  logic          s_is_hit, s_is_free, s_better;
  logic [31:0]   s_ident;
  logic [CW-1:0] s_cnt;
  logic          p_own, p_match, p_free, p_drop, pair_op;

  assign s_ident   = sess_ident_q[s_idx_q];
  assign s_cnt     = sess_cnt_q[s_idx_q];
  assign s_is_hit  = sess_vld_q[s_idx_q] && (s_ident == id_q);
  assign s_is_free = !sess_vld_q[s_idx_q];
  assign s_better  = sess_vld_q[s_idx_q] &&
                     (!best_q || (s_cnt < best_cnt_q) ||
                      ((s_cnt == best_cnt_q) && (s_ident < best_id_q)));

  assign p_own   = cmp_v_q && pv_q[cmp_idx_q] && (ro_q == hit_slot_q);
  assign p_match = p_own && (rk_q == key_q);
  assign p_free  = cmp_v_q && !pv_q[cmp_idx_q];
  // delete session drops every pair of the slot, delete key only the matching one
  assign p_drop  = ((op_q == llst_pkg::OP_DEL_SESS) && p_own) ||
                   ((op_q == llst_pkg::OP_DEL_KEY) && p_match);

  assign pair_op = (op_q == llst_pkg::OP_ADD_KEY) || (op_q == llst_pkg::OP_DEL_SESS) ||
                   (op_q == llst_pkg::OP_DEL_KEY);

  assign stat_o.s_last    = (s_idx_q == SLast);
  assign stat_o.p_last    = (p_idx_q == PLast);
  assign stat_o.p_needed  = hit_q && pair_op;
  assign stat_o.out_stall = out_valid_q && !out_ready_i;

  // operation word, scan accumulators, pair contents and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= op_i;
      id_q  <= session_id_i;
      key_q <= client_key_i;
    end
    if (cmd_i.s_step) begin
      if (s_is_hit && !hit_q) hit_slot_q <= s_idx_q;
      if (s_is_free && !sfree_q) sfree_slot_q <= s_idx_q;
      if (s_better) begin
        best_cnt_q <= s_cnt;
        best_id_q  <= s_ident;
      end
    end
    if (cmd_i.p_step) begin
      rk_q      <= pair_key_mem[p_idx_q];
      ro_q      <= pair_owner_mem[p_idx_q];
      cmp_idx_q <= p_idx_q;
    end
    if (p_free && !pfree_q) pfree_idx_q <= cmp_idx_q;
    if (cmd_i.commit) begin
      status_q <= llst_pkg::ST_DONE;
      found_q  <= 1'b0;
      sel_q    <= '0;
      case (op_q)
        llst_pkg::OP_ADD_SESS: begin
          if (!hit_q && !sfree_q) status_q <= llst_pkg::ST_FULL;
        end
        llst_pkg::OP_ADD_KEY: begin
          if (hit_q && !match_q && !pfree_q) status_q <= llst_pkg::ST_FULL;
        end
        llst_pkg::OP_FIND: begin
          if (best_q) begin
            found_q <= 1'b1;
            sel_q   <= best_id_q;
          end else begin
            status_q <= llst_pkg::ST_EMPTY;
          end
        end
        default: ;
      endcase
      if ((op_q == llst_pkg::OP_ADD_KEY) && hit_q && !match_q && pfree_q) begin
        pair_key_mem[pfree_idx_q]   <= key_q;
        pair_owner_mem[pfree_idx_q] <= hit_slot_q;
      end
    end
  end

  // session contents: written on commit only
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      case (op_q)
        llst_pkg::OP_ADD_SESS: begin
          if (!hit_q && sfree_q) begin
            sess_ident_q[sfree_slot_q] <= id_q;
            sess_cnt_q[sfree_slot_q]   <= '0;
          end
        end
        llst_pkg::OP_ADD_KEY: begin
          if (hit_q && !match_q && pfree_q)
            sess_cnt_q[hit_slot_q] <= sess_cnt_q[hit_slot_q] + 1'b1;
        end
        llst_pkg::OP_DEL_SESS: begin
          if (hit_q) sess_cnt_q[hit_slot_q] <= '0;
        end
        llst_pkg::OP_DEL_KEY: begin
          if (hit_q && match_q && (sess_cnt_q[hit_slot_q] != '0))
            sess_cnt_q[hit_slot_q] <= sess_cnt_q[hit_slot_q] - 1'b1;
        end
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sess_vld_q  <= '0;
      pv_q        <= '0;
      s_idx_q     <= '0;
      hit_q       <= 1'b0;
      sfree_q     <= 1'b0;
      best_q      <= 1'b0;
      p_idx_q     <= '0;
      cmp_v_q     <= 1'b0;
      match_q     <= 1'b0;
      pfree_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.s_clr) begin
        s_idx_q <= '0;
        hit_q   <= 1'b0;
        sfree_q <= 1'b0;
        best_q  <= 1'b0;
      end else if (cmd_i.s_step) begin
        s_idx_q <= s_idx_q + 1'b1;
        if (s_is_hit) hit_q <= 1'b1;
        if (s_is_free) sfree_q <= 1'b1;
        if (s_better) best_q <= 1'b1;
      end

      cmp_v_q <= cmd_i.p_step;
      if (cmd_i.p_clr) begin
        p_idx_q <= '0;
        match_q <= 1'b0;
        pfree_q <= 1'b0;
      end else begin
        if (cmd_i.p_step) p_idx_q <= p_idx_q + 1'b1;
        if (p_match) match_q <= 1'b1;
        if (p_free) pfree_q <= 1'b1;
      end
      // drop pairs on the fly for the delete operations
      if (p_drop) pv_q[cmp_idx_q] <= 1'b0;

      if (cmd_i.commit) begin
        if ((op_q == llst_pkg::OP_ADD_SESS) && !hit_q && sfree_q)
          sess_vld_q[sfree_slot_q] <= 1'b1;
        if ((op_q == llst_pkg::OP_DEL_SESS) && hit_q)
          sess_vld_q[hit_slot_q] <= 1'b0;
        if ((op_q == llst_pkg::OP_ADD_KEY) && hit_q && !match_q && pfree_q)
          pv_q[pfree_idx_q] <= 1'b1;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign found_o            = found_q;
  assign selected_session_o = sel_q;

endmodule

>>> src/least_loaded_session_table_core.sv
// Least-loaded session table: sessions with client key sets, one result per operation.
// Each operation word first walks the session table one slot per cycle. Add session,
// find, unknown-session cases and unused codes then go through pair selection to the
// commit. Add key, delete key and delete session on a known session also walk the pair
// store one entry per cycle through its single registered read port, then a drain
// state, before the commit. A new word is taken when the previous one is committed; a
// committed result waits in the output register while the next word is processed.
// Reset clears the valid bits of both stores at once; the contents of free entries are
// never read.
module least_loaded_session_table_core #(
  parameter int unsigned MAX_SESSIONS = llst_pkg::DefMaxSessions,
  parameter int unsigned MAX_PAIRS    = llst_pkg::DefMaxPairs
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  llst_in_if.sink     in_i,
  llst_out_if.source  out_o
);

  llst_pkg::llst_cmd_t  cmd;
  llst_pkg::llst_stat_t stat;
  logic                 in_ready;

  assign in_i.ready = in_ready;

  llst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  llst_dp #(
    .MAX_SESSIONS (MAX_SESSIONS),
    .MAX_PAIRS    (MAX_PAIRS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .op_i               (in_i.op),
    .session_id_i       (in_i.session_id),
    .client_key_i       (in_i.client_key),
    .out_valid_o        (out_o.valid),
    .out_ready_i        (out_o.ready),
    .status_o           (out_o.status),
    .found_o            (out_o.found),
    .selected_session_o (out_o.selected_session)
  );

endmodule

>>> bench/tb_top.sv
// Testbench for the least-loaded session table: random operation words checked against a model.
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned NSESS = llst_pkg::DefMaxSessions;
  localparam int unsigned NPAIR = llst_pkg::DefMaxPairs;
  localparam int unsigned SLOW_CYCLES = NSESS + NPAIR + 4;
  localparam longint unsigned CYCLE_LIMIT = 64'd3000000;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] session_id;
    logic [31:0] client_key;
  } op_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [31:0] selected_session;
  } res_word_t;

  logic clk_i;
  logic rst_ni;

  llst_in_if  in_ch ();
  llst_out_if out_ch ();

  least_loaded_session_table_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  // Shadow copy of the table.
  logic [31:0] sh_ident [NSESS];
  logic        sh_svalid [NSESS];
  int unsigned sh_count [NSESS];
  logic [31:0] sh_pkey [NPAIR];
  int unsigned sh_powner [NPAIR];
  logic        sh_pvalid [NPAIR];

  op_word_t  pending_ops [$];
  res_word_t expected_res [$];
  int unsigned errors;
  longint unsigned cycles;
  logic stim_done;

  logic [31:0] id_pool [8];
  logic [31:0] key_pool [8];

  task automatic report(input string what);
    $display("error: %s", what);
    errors++;
  endtask

  task automatic queue_op(input op_word_t w);
    pending_ops.insert(pending_ops.size(), w);
  endtask

  function automatic int find_slot(input logic [31:0] id);
    for (int s = 0; s < NSESS; s++)
      if (sh_svalid[s] && sh_ident[s] == id) return s;
    return -1;
  endfunction

  function automatic int find_pair(input int slot, input logic [31:0] key);
    for (int p = 0; p < NPAIR; p++)
      if (sh_pvalid[p] && sh_powner[p] == slot && sh_pkey[p] == key) return p;
    return -1;
  endfunction

  function automatic res_word_t apply_op(input op_word_t w);
    res_word_t r;
    int s;
    int p;
    int best;
    r = '0;
    r.status = llst_pkg::ST_DONE;
    s = find_slot(w.session_id);
    case (w.op)
      llst_pkg::OP_ADD_SESS: begin
        if (s < 0) begin
          r.status = llst_pkg::ST_FULL;
          for (int i = 0; i < NSESS; i++) begin
            if (!sh_svalid[i]) begin
              sh_svalid[i] = 1'b1;
              sh_ident[i] = w.session_id;
              sh_count[i] = 0;
              r.status = llst_pkg::ST_DONE;
              break;
            end
          end
        end
      end
      llst_pkg::OP_ADD_KEY: begin
        if (s >= 0 && find_pair(s, w.client_key) < 0) begin
          r.status = llst_pkg::ST_FULL;
          for (int i = 0; i < NPAIR; i++) begin
            if (!sh_pvalid[i]) begin
              sh_pvalid[i] = 1'b1;
              sh_pkey[i] = w.client_key;
              sh_powner[i] = s;
              sh_count[s]++;
              r.status = llst_pkg::ST_DONE;
              break;
            end
          end
        end
      end
      llst_pkg::OP_DEL_SESS: begin
        if (s >= 0) begin
          for (int i = 0; i < NPAIR; i++)
            if (sh_pvalid[i] && sh_powner[i] == s) sh_pvalid[i] = 1'b0;
          sh_svalid[s] = 1'b0;
          sh_count[s] = 0;
        end
      end
      llst_pkg::OP_DEL_KEY: begin
        if (s >= 0) begin
          p = find_pair(s, w.client_key);
          if (p >= 0) begin
            sh_pvalid[p] = 1'b0;
            if (sh_count[s] > 0) sh_count[s]--;
          end
        end
      end
      llst_pkg::OP_FIND: begin
        best = -1;
        for (int i = 0; i < NSESS; i++) begin
          if (sh_svalid[i] && (best < 0 || sh_count[i] < sh_count[best] ||
              (sh_count[i] == sh_count[best] && sh_ident[i] < sh_ident[best])))
            best = i;
        end
        if (best < 0) begin
          r.status = llst_pkg::ST_EMPTY;
        end else begin
          r.found = 1'b1;
          r.selected_session = sh_ident[best];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic op_word_t make_op(input logic [2:0] op, input logic [31:0] id,
                                       input logic [31:0] key);
    op_word_t w;
    w.op = op;
    w.session_id = id;
    w.client_key = key;
    return w;
  endfunction

  function automatic op_word_t random_op();
    logic [2:0] op;
    logic [31:0] id;
    logic [31:0] key;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 12) op = llst_pkg::OP_ADD_SESS;
    else if (r < 62) op = llst_pkg::OP_ADD_KEY;
    else if (r < 66) op = llst_pkg::OP_DEL_SESS;
    else if (r < 80) op = llst_pkg::OP_DEL_KEY;
    else if (r < 96) op = llst_pkg::OP_FIND;
    else op = 3'($urandom_range(5, 7));
    id = ($urandom_range(0, 9) == 0) ? $urandom() : id_pool[$urandom_range(0, 7)];
    key = ($urandom_range(0, 2) == 0) ? key_pool[$urandom_range(0, 7)] : $urandom();
    return make_op(op, id, key);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Stimulus: directed corners, then pools of ids and keys for deep coverage.
  initial begin
    errors = 0;
    stim_done = 1'b0;
    for (int i = 0; i < NSESS; i++) begin
      sh_ident[i] = '0; sh_svalid[i] = 1'b0; sh_count[i] = 0;
    end
    for (int i = 0; i < NPAIR; i++) begin
      sh_pkey[i] = '0; sh_powner[i] = 0; sh_pvalid[i] = 1'b0;
    end
    queue_op(make_op(llst_pkg::OP_FIND, 32'h0, 32'h0));
    queue_op(make_op(llst_pkg::OP_ADD_KEY, 32'h5, 32'h1));
    queue_op(make_op(llst_pkg::OP_DEL_KEY, 32'h5, 32'h1));
    queue_op(make_op(llst_pkg::OP_DEL_SESS, 32'h5, 32'h0));
    queue_op(make_op(llst_pkg::OP_ADD_SESS, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    queue_op(make_op(llst_pkg::OP_ADD_SESS, 32'h0, 32'h0));
    queue_op(make_op(llst_pkg::OP_ADD_SESS, 32'h0, 32'h0));
    queue_op(make_op(llst_pkg::OP_FIND, 32'hFFFF_FFFF, 32'h0));
    queue_op(make_op(llst_pkg::OP_ADD_KEY, 32'h0, 32'hFFFF_FFFF));
    queue_op(make_op(llst_pkg::OP_ADD_KEY, 32'h0, 32'hFFFF_FFFF));
    queue_op(make_op(llst_pkg::OP_ADD_KEY, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    queue_op(make_op(llst_pkg::OP_ADD_KEY, 32'h0, 32'h0));
    queue_op(make_op(llst_pkg::OP_FIND, 32'h0, 32'h0));
    queue_op(make_op(llst_pkg::OP_DEL_KEY, 32'h0, 32'h1234));
    queue_op(make_op(llst_pkg::OP_DEL_KEY, 32'h0, 32'hFFFF_FFFF));
    queue_op(make_op(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    queue_op(make_op(3'd7, 32'h0, 32'h0));
    // Fill the session table past full.
    for (int i = 0; i <= NSESS; i++)
      queue_op(make_op(llst_pkg::OP_ADD_SESS, 32'h100 + i, 32'h0));
    // Fill the pair store past full, then free it.
    for (int i = 0; i <= NPAIR; i++)
      queue_op(make_op(llst_pkg::OP_ADD_KEY, 32'h100 + (i % 4), $urandom()));
    queue_op(make_op(llst_pkg::OP_FIND, 32'h0, 32'h0));
    for (int i = 0; i <= NSESS; i++)
      queue_op(make_op(llst_pkg::OP_DEL_SESS, 32'h100 + i, 32'h0));
    queue_op(make_op(llst_pkg::OP_DEL_SESS, 32'h0, 32'h0));
    queue_op(make_op(llst_pkg::OP_DEL_SESS, 32'hFFFF_FFFF, 32'h0));
    queue_op(make_op(llst_pkg::OP_FIND, 32'h0, 32'h0));
    for (int g = 0; g < 5; g++) begin
      for (int i = 0; i < 8; i++) begin
        id_pool[i] = (g % 2 == 0) ? 32'($urandom_range(0, 20)) : $urandom();
        key_pool[i] = $urandom();
      end
      for (int i = 0; i < 300; i++) queue_op(random_op());
    end
    stim_done = 1'b1;
  end

  // Driver: bursts of words separated by random gaps.
  int unsigned burst_left;
  int unsigned gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.op <= '0;
      in_ch.session_id <= '0;
      in_ch.client_key <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      automatic logic busy = in_ch.valid && !in_ch.ready;
      if (!busy) begin
        if (in_ch.valid) expected_res.insert(expected_res.size(), apply_op(op_word_t'({
            in_ch.op, in_ch.session_id, in_ch.client_key})));
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_ch.valid <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          automatic op_word_t w = pending_ops.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.op <= w.op;
          in_ch.session_id <= w.session_id;
          in_ch.client_key <= w.client_key;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 300);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor with a stall pattern of its own on the result side.
  int unsigned stall_phase;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      stall_phase <= 0;
    end else begin
      stall_phase <= stall_phase + 1;
      out_ch.ready <= (stall_phase[9:8] == 2'd3) ? 1'b1 : (stall_phase % 7 != 3 &&
                      $urandom_range(0, 3) != 0);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_res.size() == 0) begin
          report("result word with nothing expected");
        end else begin
          automatic res_word_t e = expected_res.pop_front();
          if (out_ch.status !== e.status)
            report($sformatf("status %0d, expected %0d", out_ch.status, e.status));
          if (out_ch.found !== e.found)
            report($sformatf("found %0d, expected %0d", out_ch.found, e.found));
          if (out_ch.selected_session !== e.selected_session)
            report($sformatf("session %h, expected %h", out_ch.selected_session,
                             e.selected_session));
        end
      end
    end
  end

  initial begin
    cycles = 0;
    @(posedge rst_ni);
    while (!(stim_done && pending_ops.size() == 0 && !in_ch.valid &&
             expected_res.size() == 0) && cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("least_loaded_session_table_core: mismatch");
      $finish;
    end else begin
      repeat (2 * SLOW_CYCLES) @(posedge clk_i);
      if (errors == 0) begin
        $display("least_loaded_session_table_core: match");
      end else begin
        $display("least_loaded_session_table_core: mismatch");
      end
      $finish;
    end
  end

endmodule

>>> filelist.f
src/llst_pkg.sv
src/llst_if.sv
src/llst_ctrl.sv
src/llst_dp.sv
src/least_loaded_session_table_core.sv
bench/tb_top.sv
